// ----- hw/rtl/fspwm_pkg.sv -----
// ----------------------------------------------------------------------------
// fspwm_pkg
// Shared types and codes of the fading soft PWM controller.
// ----------------------------------------------------------------------------
package fspwm_pkg;

  // Default channel count and limits
  localparam int unsigned ChannelsDef = 4;
  localparam int unsigned ChannelsMax = 8;

  // Duty limits and fade step constants
  localparam logic [7:0] DutyMax     = 8'hff;
  localparam logic [7:0] DutyZero    = 8'h00;
  localparam logic [7:0] StepMin     = 8'd3;
  // Divide by ten as (d * 205) >> 11, exact for all 8-bit d
  localparam logic [7:0] Recip10     = 8'd205;
  localparam int unsigned Recip10Shift = 11;

  // Action codes
  localparam logic [2:0] ActFadeTick = 3'd0;
  localparam logic [2:0] ActPwmTick  = 3'd1;
  localparam logic [2:0] ActWrDuty   = 3'd2;
  localparam logic [2:0] ActWrMode   = 3'd3;
  localparam logic [2:0] ActRead     = 3'd4;

  // Fade mode codes
  localparam logic [2:0] ModeNone  = 3'd0;
  localparam logic [2:0] ModeIn    = 3'd1;
  localparam logic [2:0] ModeOut   = 3'd2;
  localparam logic [2:0] ModeInOut = 3'd3;
  localparam logic [2:0] ModeOutIn = 3'd4;
  // Highest mode code a bus write may set
  localparam logic [7:0] ModeWrMax = 8'd3;

  // Status codes
  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatBadChan = 2'd1;
  localparam logic [1:0] StatBadMode = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } fspwm_state_e;

  // Input item
  typedef struct packed {
    logic [2:0] action;
    logic [2:0] channel;
    logic [7:0] value;
  } fspwm_in_t;

  // Result item
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_duty;
    logic [2:0] read_mode;
    logic [7:0] pin_levels;
    logic       any_fading;
  } fspwm_out_t;

endpackage

// ----- hw/rtl/fading_soft_pwm_controller_top.sv -----
// ----------------------------------------------------------------------------
// fading_soft_pwm_controller_top
// Multi-channel PWM with per-channel fade; duty and mode live in small
// synchronous memories that a sweep reads, updates and writes back.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes one item: a
//   fade tick, a pwm tick, a duty write, a mode write or a channel read.
//   Output channel (out_valid_o / out_stall_i / out_item_o) gives exactly one
//   result item per input item: status, duty and mode of the addressed
//   channel, all pin levels and the fade activity flag.
//   Every item sweeps all CHANNELS entries of the duty and mode memories,
//   one entry per cycle through the single read port; the write-back of one
//   entry overlaps the read of the next. The input stalls from acceptance
//   until the result is loaded into the output register, so a new item is
//   taken only once the sweep of the last one has finished.
//   The result sits in an output register, so the next item is accepted
//   while a result still waits. If the receiver stalls longer, the finished
//   sweep holds in its last state and the input stalls.
//   Reset clears the pwm counter and marks every memory entry invalid; an
//   invalid entry reads as duty 0, mode none. No clearing pass is needed.
// ----------------------------------------------------------------------------
module fading_soft_pwm_controller_top #(
  parameter int unsigned CHANNELS = fspwm_pkg::ChannelsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  fspwm_pkg::fspwm_in_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output fspwm_pkg::fspwm_out_t out_item_o
);
  import fspwm_pkg::*;

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(CHANNELS - 1);
  localparam logic [3:0] ChanCount = 4'(CHANNELS);

  // State memories and their valid bits
  logic [7:0] duty_mem [CHANNELS];
  logic [2:0] mode_mem [CHANNELS];
  logic [CHANNELS-1:0] valid_q;

  fspwm_state_e state_q, state_d;

  fspwm_in_t   item_q;
  fspwm_out_t  out_q;
  logic        out_valid_q;
  logic [7:0]  pwm_cnt_q;

  logic [IdxW-1:0] rd_idx_q;
  logic            issue_q;
  logic            proc_vld_q;
  logic [IdxW-1:0] proc_idx_q;
  logic [7:0]      rd_duty_q;
  logic [2:0]      rd_mode_q;
  logic            rd_ok_q;

  logic [7:0] pins_q;
  logic       active_q;
  logic [7:0] cap_duty_q;
  logic [2:0] cap_mode_q;

  logic in_fire;
  logic out_free;
  logic load_out;
  logic proc_last;
  logic ch_ok;
  logic [1:0] status;

  logic [7:0]  cur_d;
  logic [2:0]  cur_m;
  logic [15:0] prod;
  logic [7:0]  quot;
  logic [7:0]  step;
  logic [7:0]  new_d;
  logic [2:0]  new_m;
  logic        fading;
  logic        is_sel;
  logic        pin_bit;

  assign in_fire   = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign proc_last = proc_vld_q && (proc_idx_q == IdxLast);
  assign ch_ok     = {1'b0, item_q.channel} < ChanCount;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (proc_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_SWEEP:  in_stall_o = 1'b1;
      ST_FINISH: load_out   = out_free;
      default:   in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Update one entry: fade step, or a bus write at the addressed channel
  always_comb begin
    cur_d   = rd_ok_q ? rd_duty_q : DutyZero;
    cur_m   = rd_ok_q ? rd_mode_q : ModeNone;
    prod    = 16'(cur_d) * 16'(Recip10);
    quot    = 8'(prod >> Recip10Shift);
    step    = (quot < StepMin) ? StepMin : quot;
    new_d   = cur_d;
    new_m   = cur_m;
    fading  = 1'b0;
    is_sel  = ch_ok && (item_q.channel == 3'(proc_idx_q));
    case (item_q.action)
      ActFadeTick: begin
        if (cur_m == ModeIn || cur_m == ModeInOut) begin
          fading = 1'b1;
          if (cur_d < (DutyMax - step)) begin
            new_d = cur_d + step;
          end else begin
            new_d = DutyMax;
            new_m = (cur_m == ModeIn) ? ModeNone : ModeOutIn;
          end
        end else if (cur_m == ModeOut || cur_m == ModeOutIn) begin
          fading = 1'b1;
          if (cur_d > step) begin
            new_d = cur_d - step;
          end else begin
            new_d = DutyZero;
            new_m = (cur_m == ModeOut) ? ModeNone : ModeInOut;
          end
        end
      end
      ActWrDuty: begin
        if (is_sel) new_d = item_q.value;
      end
      ActWrMode: begin
        if (is_sel && item_q.value <= ModeWrMax) new_m = item_q.value[2:0];
      end
      default: begin
        new_d = cur_d;
      end
    endcase
    pin_bit = (new_d == DutyMax) || ((new_d != DutyZero) && (pwm_cnt_q < new_d));
  end

  // Status from the item alone
  always_comb begin
    status = StatOk;
    case (item_q.action)
      ActWrDuty, ActRead: begin
        if (!ch_ok) status = StatBadChan;
      end
      ActWrMode: begin
        if (!ch_ok) status = StatBadChan;
        else if (item_q.value > ModeWrMax) status = StatBadMode;
      end
      default: status = StatOk;
    endcase
  end

  // Memories: registered read, write-back of the processed entry
  always_ff @(posedge clk_i) begin
    if (issue_q) begin
      rd_duty_q <= duty_mem[rd_idx_q];
      rd_mode_q <= mode_mem[rd_idx_q];
    end
    if (proc_vld_q) begin
      duty_mem[proc_idx_q] <= new_d;
      mode_mem[proc_idx_q] <= new_m;
    end
  end

  // Sweep control, valid bits and pwm counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      pwm_cnt_q  <= '0;
      issue_q    <= 1'b0;
      proc_vld_q <= 1'b0;
      rd_idx_q   <= '0;
      proc_idx_q <= '0;
      rd_ok_q    <= 1'b0;
    end else begin
      if (in_fire) begin
        rd_idx_q <= '0;
        issue_q  <= 1'b1;
        if (in_item_i.action == ActPwmTick) pwm_cnt_q <= pwm_cnt_q + 8'd1;
      end else if (issue_q) begin
        if (rd_idx_q == IdxLast) issue_q <= 1'b0;
        else rd_idx_q <= rd_idx_q + IdxW'(1);
      end
      proc_vld_q <= issue_q;
      if (issue_q) begin
        proc_idx_q <= rd_idx_q;
        rd_ok_q    <= valid_q[rd_idx_q];
      end
      if (proc_vld_q) valid_q[proc_idx_q] <= 1'b1;
    end
  end

  // Hold the item and gather pins, activity and the read-back during the sweep
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q     <= in_item_i;
      pins_q     <= '0;
      active_q   <= 1'b0;
      cap_duty_q <= DutyZero;
      cap_mode_q <= ModeNone;
    end else if (proc_vld_q) begin
      pins_q[3'(proc_idx_q)] <= pin_bit;
      if (fading) active_q <= 1'b1;
      if (is_sel) begin
        cap_duty_q <= new_d;
        cap_mode_q <= new_m;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.status     <= status;
      out_q.read_duty  <= cap_duty_q;
      out_q.read_mode  <= cap_mode_q;
      out_q.pin_levels <= pins_q;
      out_q.any_fading <= active_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
